/* hdl/svpwm_pkg.sv */
`default_nettype none
package svpwm_pkg;
  localparam int FRAC_BITS = 24;
  localparam int DW = 32;
  localparam int REG_W = 31;
  localparam int CNT_W = $clog2(DW + 1);
  localparam logic [REG_W-1:0] PERIOD_RESET = 31'd838860800;
  localparam logic [REG_W-1:0] GAIN_RESET = 31'd121079121;
  localparam logic [DW-1:0] SQRT3_HALF = DW'(64'd929887697 >> (30 - FRAC_BITS));
  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_GAIN = 1'b1;

  function automatic logic [2:0] code_to_sector(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd1: s = 3'd2;
      3'd2: s = 3'd6;
      3'd3: s = 3'd1;
      3'd4: s = 3'd4;
      3'd5: s = 3'd3;
      3'd6: s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

/* hdl/space_vector_pwm_timing_unit.sv */
`default_nettype none
// Sequence: three shift-add multiplies through one serial multiplier
//   (alpha*sqrt3/2, then the two active times) plus four further steps (u values,
//   sector, zero time, output); while no sector is found the time steps are skipped.
// Throughput: one word at a time; s_tready is
//   high only when idle, and a held result stalls the block before its output.
// Reset (rst, synchronous): registers return to defaults, held sector and
//   held phase times clear to zero, output empty.
module space_vector_pwm_timing_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // alpha_voltage[31:0], beta_voltage[63:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,  // phase_a[31:0], phase_b[63:32], phase_c[95:64]
  output logic [2:0]       m_tuser,  // sector_number
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data
);
  import svpwm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_ALPHA, S_UVALS, S_MUL_X, S_MUL_Y, S_TIMES, S_ZERO, S_OUT
  } state_t;

  state_t state;
  logic [REG_W-1:0] pwm_period, duration_gain;
  logic [2:0] held_sector;
  logic [2:0] sector_out;
  logic [DW-1:0] ta, tb, tc;
  logic [DW-1:0] beta, u1, u2, u3, xv, yv, zv;
  // serial multiplier: multiplicand and multiplier shifted one bit a cycle
  logic [2*DW-1:0] acc, mcand, acc_step, gain_ext;
  logic [DW-1:0] mplier;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0] mul_res, prod;
  logic [2:0] sec_new;
  logic [DW-1:0] hb;
  logic out_free;

  // one shift-add step; the top multiplier bit weighs negative
  assign acc_step = !mplier[0] ? acc :
                    (cnt == CNT_W'(DW - 1)) ? acc - mcand : acc + mcand;
  // product of the step in flight, and of the finished alpha multiply
  assign prod = acc_step[FRAC_BITS +: DW];
  assign mul_res = acc[FRAC_BITS +: DW];
  assign gain_ext = {{(2*DW-REG_W){1'b0}}, duration_gain};
  assign hb = {beta[DW-1], beta[DW-1:1]};
  assign s_tready = (state == S_IDLE);
  // output register free: empty, or its word leaves this cycle
  assign out_free = !m_tvalid || m_tready;

  function automatic logic pos(input logic [DW-1:0] v);
    return (v != '0) && !v[DW-1];
  endfunction

  assign sec_new = code_to_sector({pos(u3), pos(u2), pos(u1)});

  function automatic logic [DW-1:0] pick_x(input logic [2:0] s, input logic [DW-1:0] a,
                                             input logic [DW-1:0] b, input logic [DW-1:0] c);
    logic [DW-1:0] r;
    case (s)
      3'd1, 3'd2: r = b;
      3'd3, 3'd4: r = a;
      default:    r = c;
    endcase
    return r;
  endfunction

  function automatic logic [DW-1:0] pick_y(input logic [2:0] s, input logic [DW-1:0] a,
                                             input logic [DW-1:0] b, input logic [DW-1:0] c);
    logic [DW-1:0] r;
    case (s)
      3'd1, 3'd6: r = a;
      3'd2, 3'd3: r = c;
      default:    r = b;
    endcase
    return r;
  endfunction

  logic [DW-1:0] full, part, zsum;
  assign zsum = DW'(pwm_period) - xv - yv;
  assign full = xv + yv + zv;
  assign part = yv + zv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pwm_period <= PERIOD_RESET;
      duration_gain <= GAIN_RESET;
      held_sector <= '0;
      sector_out <= '0;
      ta <= '0; tb <= '0; tc <= '0;
      m_tvalid <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PERIOD) pwm_period <= cfg_data;
        else duration_gain <= cfg_data;
      end
      if (state == S_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid) begin
          beta <= s_tdata[63:32];
          acc <= '0;
          mcand <= {{DW{s_tdata[31]}}, s_tdata[31:0]};
          mplier <= SQRT3_HALF;
          cnt <= '0;
          state <= S_MUL_ALPHA;
        end
        S_MUL_ALPHA, S_MUL_X, S_MUL_Y: begin
          if (cnt != CNT_W'(DW - 1)) begin
            acc <= acc_step;
            mcand <= mcand << 1;
            mplier <= mplier >> 1;
            cnt <= cnt + 1'b1;
          end else begin
            cnt <= '0;
            case (state)
              S_MUL_ALPHA: begin
                acc <= acc_step;
                state <= S_UVALS;
              end
              S_MUL_X: begin
                // even sectors take the negated product
                xv <= held_sector[0] ? prod : DW'(0) - prod;
                acc <= '0;
                mcand <= gain_ext;
                mplier <= pick_y(held_sector, u1, u2, u3);
                state <= S_MUL_Y;
              end
              default: begin
                yv <= held_sector[0] ? prod : DW'(0) - prod;
                state <= S_TIMES;
              end
            endcase
          end
        end
        S_UVALS: begin
          u1 <= beta;
          u2 <= mul_res - hb;
          u3 <= (DW'(0) - mul_res) - hb;
          state <= S_ZERO;
        end
        S_ZERO: begin
          if (sec_new != 3'd0) held_sector <= sec_new;
          if (sec_new == 3'd0 && held_sector == 3'd0) begin
            // no sector yet: repeat the held (zero) times
            state <= S_OUT;
          end else begin
            acc <= '0;
            mcand <= gain_ext;
            mplier <= pick_x(sec_new != 3'd0 ? sec_new : held_sector, u1, u2, u3);
            state <= S_MUL_X;
          end
        end
        S_TIMES: begin
          zv <= {zsum[DW-1], zsum[DW-1:1]};
          state <= S_OUT;
        end
        S_OUT: if (out_free) begin
          if (held_sector != 3'd0) begin
            case (held_sector)
              3'd1: begin ta <= full; tb <= part; tc <= zv; end
              3'd2: begin ta <= part; tb <= full; tc <= zv; end
              3'd3: begin ta <= zv; tb <= full; tc <= part; end
              3'd4: begin ta <= zv; tb <= part; tc <= full; end
              3'd5: begin ta <= part; tb <= zv; tc <= full; end
              default: begin ta <= full; tb <= zv; tc <= part; end
            endcase
          end
          sector_out <= held_sector;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {tc, tb, ta};
  assign m_tuser = sector_out;

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_sec: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= 3'd6)) else $error("bad sector");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cnt == '0)) else $error("counter not cleared");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output word changed while waiting");
endmodule
`default_nettype wire

/* tb/sv/svpwm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module svpwm_checker
  import svpwm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [95:0] m_tdata,
  input  wire logic [2:0]  m_tuser,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_data,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic [2:0]         sector;
    logic signed [31:0] tc;
    logic signed [31:0] tb;
    logic signed [31:0] ta;
  } timing_t;

  localparam logic signed [31:0] HALF_SQRT3 = 32'sd14529495;

  timing_t                 timing_q[$];
  logic [REG_W-1:0]        period_r, gain_r;
  logic [2:0]              sector_r;
  logic signed [31:0]      times_r[3];

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = a * b;
    s = p >>> FRAC_BITS;
    return s[31:0];
  endfunction

  // sector lookup from the three sign bits {u3>0, u2>0, u1>0}
  function automatic logic [2:0] sign_sector(input logic [2:0] code);
    case (code)
      3'b001: return 3'd2;
      3'b010: return 3'd6;
      3'b011: return 3'd1;
      3'b100: return 3'd4;
      3'b101: return 3'd3;
      3'b110: return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  function automatic timing_t predict_timing(input logic signed [31:0] alpha,
                                             input logic signed [31:0] beta);
    logic signed [31:0] ra, hb, u1, u2, u3, k, ts, x, y, z, full, part;
    logic [2:0] sec;
    timing_t r;
    k  = $signed({1'b0, gain_r});
    ts = $signed({1'b0, period_r});
    ra = qmul(alpha, HALF_SQRT3);
    hb = beta >>> 1;
    u1 = beta;
    u2 = ra - hb;
    u3 = -ra - hb;
    sec = sign_sector({u3 > 0, u2 > 0, u1 > 0});
    if (sec != 0) sector_r = sec;
    x = 0;
    y = 0;
    case (sector_r)
      3'd1: begin x = qmul(k, u2);  y = qmul(k, u1);  end
      3'd2: begin x = -qmul(k, u2); y = -qmul(k, u3); end
      3'd3: begin x = qmul(k, u1);  y = qmul(k, u3);  end
      3'd4: begin x = -qmul(k, u1); y = -qmul(k, u2); end
      3'd5: begin x = qmul(k, u3);  y = qmul(k, u2);  end
      3'd6: begin x = -qmul(k, u3); y = -qmul(k, u1); end
      default: ;
    endcase
    if (sector_r != 0) begin
      z = (ts - x - y) >>> 1;
      full = x + y + z;
      part = y + z;
      case (sector_r)
        3'd1: times_r = '{full, part, z};
        3'd2: times_r = '{part, full, z};
        3'd3: times_r = '{z, full, part};
        3'd4: times_r = '{z, part, full};
        3'd5: times_r = '{part, z, full};
        default: times_r = '{full, z, part};
      endcase
    end
    r.ta = times_r[0];
    r.tb = times_r[1];
    r.tc = times_r[2];
    r.sector = sector_r;
    return r;
  endfunction

  assign pending = timing_q.size();

  always @(posedge clk) begin
    timing_t e;
    if (rst) begin
      period_r <= PERIOD_RESET;
      gain_r   <= GAIN_RESET;
      sector_r = 0;
      times_r  = '{0, 0, 0};
      timing_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PERIOD) period_r <= cfg_data;
        else gain_r <= cfg_data;
      end
      if (s_tvalid && s_tready)
        timing_q.push_back(predict_timing(s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        if (timing_q.size() == 0) begin
          $display("%0t: unexpected word a=%h b=%h c=%h sector=%0d", $time,
                   m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser);
          errors++;
        end else begin
          e = timing_q.pop_front();
          if (m_tdata[31:0] !== e.ta) begin
            $display("%0t: phase A exp %h got %h", $time, e.ta, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] !== e.tb) begin
            $display("%0t: phase B exp %h got %h", $time, e.tb, m_tdata[63:32]);
            errors++;
          end
          if (m_tdata[95:64] !== e.tc) begin
            $display("%0t: phase C exp %h got %h", $time, e.tc, m_tdata[95:64]);
            errors++;
          end
          if (m_tuser !== e.sector) begin
            $display("%0t: sector exp %0d got %0d", $time, e.sector, m_tuser);
            errors++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* tb/sv/tb_space_vector_pwm_timing_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_space_vector_pwm_timing_unit;
  import svpwm_pkg::*;

  localparam int STALL_LIMIT = 3000;  // idle cycles before the watchdog trips
  localparam int SETTLE = 120;        // exceeds the block's accept-to-output latency
  localparam logic signed [31:0] ONE = 32'sd16777216;  // 1.0 in Q24

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // alpha_voltage[31:0], beta_voltage[63:32]
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [95:0] m_tdata;        // phase_a[31:0], phase_b[63:32], phase_c[95:64]
  logic [2:0]  m_tuser;        // sector_number
  logic        cfg_we = 0;
  logic        cfg_index = REG_PERIOD;
  logic [30:0] cfg_data = '0;
  int          errors, pending;
  logic        hold_req = 0;   // asks the sink for one long stall
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  space_vector_pwm_timing_unit dut (.*);

  svpwm_checker chk (.*);

  // sink: random backpressure, plus one long stall on request
  initial begin
    int n;
    bit hold_used;
    hold_used = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1;
        m_tready <= 0;
        repeat (400) @(posedge clk);
      end
      n = $urandom_range(0, 99);
      if (n < 55) m_tready <= 1;
      else if (n < 95) begin
        m_tready <= 0;
      end else begin
        // occasional long stall
        m_tready <= 0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // watchdog: trips when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // mostly short gaps, some long, many back-to-back
  function automatic int pick_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) return 0;
    if (n < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // present one word; called at a posedge, returns at its acceptance edge
  task automatic send_pair(input logic signed [31:0] alpha,
                           input logic signed [31:0] beta);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {beta, alpha};
    // tready only changes at posedge, so the negedge value holds at the next edge
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // let all results come back, then give the block time to go fully idle
  task automatic drain();
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one write, after which cfg_we is held low before returning
  task automatic write_reg(input logic idx, input logic [30:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_volt();
    int n;
    n = $urandom_range(0, 9);
    if (n < 4) return $urandom();  // full range, every bit
    // realistic amplitude, up to about +/-4 V
    return ($signed($urandom_range(0, 32'h7FFF_FFFF)) >>> $urandom_range(5, 20))
           * ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  task automatic random_phase(input int count, input bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req <= 1;
      send_pair(rand_volt(), rand_volt());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero vector before any sector is found, then sign code 0 again later
    send_pair(0, 0);
    send_pair(0, 0);
    // one point per sector around the circle, plus one more on the alpha axis
    send_pair(ONE, ONE / 2);
    send_pair(0, ONE);
    send_pair(-ONE, ONE / 2);
    send_pair(-ONE, -ONE / 2);
    send_pair(0, -ONE);
    send_pair(ONE, -ONE / 2);
    send_pair(ONE, 0);
    send_pair(0, 0);  // keeps previous sector
    // field extremes
    send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_pair(32'sh8000_0000, 32'sh8000_0000);
    send_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_pair(-1, -1);
    send_pair(1, 1);
    send_pair(32'sh5555_5555, 32'shAAAA_AAAA);
    drain();

    // register extremes and random settings, each followed by a random run
    write_reg(REG_PERIOD, 31'h7FFF_FFFF);
    write_reg(REG_GAIN, 31'h7FFF_FFFF);
    random_phase(60, 0);
    drain();
    write_reg(REG_PERIOD, 31'd0);
    write_reg(REG_GAIN, 31'd0);
    send_pair(ONE, ONE / 2);
    send_pair(-ONE, -ONE);
    random_phase(40, 0);
    drain();
    write_reg(REG_PERIOD, PERIOD_RESET);
    write_reg(REG_GAIN, GAIN_RESET);
    random_phase(150, 1);  // sink stalls long in here while words keep coming
    drain();
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_PERIOD, 31'($urandom()));
      write_reg(REG_GAIN, 31'($urandom()));
      random_phase(50, 0);
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
